[design/b64_pkg.sv]
// shared types, constants and character tables for the base64url codec
package b64_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] PAD_CODE = 7'd64;
	localparam logic [6:0] BAD_CODE = 7'd65;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       error;
	} out_item_t;

	// one accepted item's worth of results, expanded by the back end
	typedef struct packed {
		logic        decode;
		logic        err;
		logic        last;
		logic [1:0]  cnt_m1;
		logic [23:0] triple;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [6:0] classify(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
		if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
		if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
		if (c == 8'h2D || c == 8'h2B) return 7'd62;
		if (c == 8'h5F || c == 8'h2F) return 7'd63;
		if (c == 8'h3D) return PAD_CODE;
		return BAD_CODE;
	endfunction

	function automatic logic [7:0] enc_char(input logic [5:0] i);
		if (i < 6'd26) return 8'h41 + {2'b00, i};
		if (i < 6'd52) return 8'h61 + {2'b00, i} - 8'd26;
		if (i < 6'd62) return 8'h30 + {2'b00, i} - 8'd52;
		if (i == 6'd62) return 8'h2D;
		return 8'h5F;
	endfunction

endpackage

[design/b64_front.sv]
// front end: mode register, group gathering, character checks, job building
module b64_front import b64_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  logic     cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     push,
	output job_t     job,
	input  q_stat_t  q_stat
);

	logic        mode_q;
	logic [17:0] gbits_q;
	logic [1:0]  gcnt_q;
	logic [1:0]  pads_q;
	logic        drop_q;

	logic [17:0] n_gbits;
	logic [1:0]  n_gcnt;
	logic [1:0]  n_pads;
	logic        n_drop;
	logic        emit;
	logic        accept;
	job_t        j;
	logic [6:0]  code;
	logic [5:0]  v6;
	logic [1:0]  pm_new;
	logic        bad;
	logic [17:0] bits;
	logic [7:0]  b;
	logic        last;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign push     = accept && emit;
	assign job      = j;

	always_comb begin
		n_gbits  = gbits_q;
		n_gcnt   = gcnt_q;
		n_pads   = pads_q;
		n_drop   = drop_q;
		emit     = 1'b0;
		b        = in_data.in_byte;
		last     = in_data.in_last;
		j        = '0;
		j.decode = mode_q;
		j.last   = last;
		code     = classify(b);
		v6       = code[5:0];
		pm_new   = pads_q;
		bad      = 1'b0;
		bits     = '0;
		if (!mode_q) begin
			if (gcnt_q == 2'd2) begin
				j.triple = {gbits_q[15:0], b};
				j.cnt_m1 = 2'd3;
				emit     = 1'b1;
			end else if (last) begin
				if (gcnt_q == 2'd0) begin
					j.triple = {b, 16'h0000};
					j.cnt_m1 = 2'd1;
				end else begin
					j.triple = {gbits_q[7:0], b, 8'h00};
					j.cnt_m1 = 2'd2;
				end
				emit = 1'b1;
			end else begin
				n_gbits = {gbits_q[9:0], b};
				n_gcnt  = gcnt_q + 2'd1;
			end
		end else if (drop_q) begin
			if (last) begin
				n_drop = 1'b0;
			end
		end else begin
			if (code == BAD_CODE) begin
				bad = 1'b1;
			end else if (code == PAD_CODE) begin
				if (gcnt_q < 2'd2) begin
					bad = 1'b1;
				end else begin
					pm_new = pads_q | ((gcnt_q == 2'd2) ? 2'b01 : 2'b10);
					v6     = 6'd0;
				end
			end else if (gcnt_q == 2'd3 && pads_q[0]) begin
				bad = 1'b1;
			end
			bits = {gbits_q[11:0], v6};
			if (bad || (last && gcnt_q == 2'd0)) begin
				// error beat ends the message; drop the rest unless this was the end
				j.err    = 1'b1;
				j.last   = 1'b1;
				j.cnt_m1 = 2'd0;
				emit     = 1'b1;
				n_drop   = !last;
			end else if (gcnt_q == 2'd3) begin
				j.triple = {gbits_q, v6};
				j.cnt_m1 = pm_new[0] ? 2'd0 : (pm_new[1] ? 2'd1 : 2'd2);
				emit     = 1'b1;
			end else if (last) begin
				if (gcnt_q == 2'd1) begin
					j.triple = {bits[11:0], 12'h000};
					j.cnt_m1 = 2'd0;
				end else begin
					j.triple = {bits, 6'd0};
					j.cnt_m1 = pm_new[0] ? 2'd0 : 2'd1;
				end
				emit = 1'b1;
			end else begin
				n_gbits = bits;
				n_gcnt  = gcnt_q + 2'd1;
				n_pads  = pm_new;
			end
		end
		if (emit) begin
			n_gbits = '0;
			n_gcnt  = '0;
			n_pads  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			gbits_q <= '0;
			gcnt_q  <= '0;
			pads_q  <= '0;
			drop_q  <= 1'b0;
		end else if (cfg_valid) begin
			mode_q  <= cfg_data;
			gbits_q <= '0;
			gcnt_q  <= '0;
			pads_q  <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			gbits_q <= n_gbits;
			gcnt_q  <= n_gcnt;
			pads_q  <= n_pads;
			drop_q  <= n_drop;
		end
	end

endmodule

[design/b64_queue.sv]
// short job queue between the front and back ends
module b64_queue import b64_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wr_job,
	input  logic    pop,
	output job_t    rd_job,
	output q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slots [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign rd_job       = slots[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[design/b64_back.sv]
// back end: expands the head job into result beats through the output register
module b64_back import b64_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  q_stat_t   q_stat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [1:0] k_q;
	logic       out_valid_q;
	out_item_t  out_data_q;
	logic       load;
	out_item_t  item;
	logic [7:0] dbyte;
	logic [5:0] sext;

	assign load      = !q_stat.empty && (!out_valid_q || !out_stall);
	assign pop       = load && (k_q == job.cnt_m1);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		case (k_q)
			2'd0: begin
				dbyte = job.triple[23:16];
				sext  = job.triple[23:18];
			end
			2'd1: begin
				dbyte = job.triple[15:8];
				sext  = job.triple[17:12];
			end
			2'd2: begin
				dbyte = job.triple[7:0];
				sext  = job.triple[11:6];
			end
			default: begin
				dbyte = 8'h00;
				sext  = job.triple[5:0];
			end
		endcase
		item.out_byte = job.err ? 8'h00 : (job.decode ? dbyte : enc_char(sext));
		item.out_last = job.last && (k_q == job.cnt_m1);
		item.error    = job.err;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q         <= pop ? 2'd0 : k_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/base64url_codec.sv]
// top level of the streaming base64url encoder and decoder
// The block takes one item per cycle while in_stall is low and gives at most one result beat per
// cycle. A write of cfg_data selects encode (0) or decode (1) and clears any partial group; write
// it only while the block is idle. The front end checks and gathers each item and hands a job for
// each item that completes a group, ends a message or is invalid (outside a dropped message) to a
// queue of QUEUE_DEPTH_P jobs; the back end expands each job into one to four beats through the
// output register. Encoding gives four beats per three bytes, so the single output port holds back
// sustained input; decoding takes one character per cycle while the output does not stall. An
// invalid character or a one-character tail gives one error beat with out_last set, and the rest
// of that message is dropped without results.
module base64url_codec import b64_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic    push;
	logic    pop;
	job_t    wr_job;
	job_t    rd_job;
	q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.job       (wr_job),
		.q_stat    (q_stat)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.q_stat (q_stat)
	);

	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job popped from an empty queue");

	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error) |-> (out_data.out_byte == 8'h00 && out_data.out_last))
		else $error("error beat carries data or lacks last");

	a_pop_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !push) |=> !pop)
		else $error("back end consumed a job that was never queued");

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the base64url codec: queued stimulus, bit-exact predictor, scoreboard
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import b64_pkg::*;

	localparam bit [8*64-1:0] URL_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
	localparam int SYM_PAD      = 64;
	localparam int SYM_BAD      = 65;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_AT      = 36;
	localparam int HOLD_CYCLES  = 300;
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data  = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	base64url_codec DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// codec state as seen by the predictor
	logic        dec_mode  = MODE_ENCODE;
	logic [17:0] grp_bits  = '0;
	logic [1:0]  grp_cnt   = '0;
	logic [1:0]  pad_seen  = '0;
	logic        drop_rest = 1'b0;

	out_item_t pending_results[$];
	in_item_t  items_to_send[$];
	out_item_t want_beat;
	int        err_count    = 0;
	int        items_queued = 0;

	function automatic logic [7:0] url_char(input int idx);
		return URL_CHARS[8*(63-idx) +: 8];
	endfunction

	function automatic int sym_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return c - "A";
		if (c >= "a" && c <= "z") return c - "a" + 26;
		if (c >= "0" && c <= "9") return c - "0" + 52;
		if (c == "-" || c == "+") return 62;
		if (c == "_" || c == "/") return 63;
		if (c == "=") return SYM_PAD;
		return SYM_BAD;
	endfunction

	task automatic push_result(input logic [7:0] b, input logic last, input logic err);
		out_item_t r;
		r = '{out_byte: b, out_last: last, error: err};
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic clear_group();
		grp_bits = '0;
		grp_cnt  = '0;
		pad_seen = '0;
	endtask

	task automatic set_mode(input logic m);
		dec_mode  = m;
		drop_rest = 1'b0;
		clear_group();
	endtask

	task automatic emit_bytes(input logic [23:0] triple, input int n, input logic last);
		for (int k = 0; k < n; k++)
			push_result(triple[16-8*k +: 8], last && k == n - 1, 1'b0);
		clear_group();
	endtask

	task automatic decode_fail(input logic last);
		clear_group();
		drop_rest = !last;
		push_result(8'h00, 1'b1, 1'b1);
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic last);
		logic [23:0] triple;
		int n;
		if (grp_cnt == 2'd2) begin
			triple = {grp_bits[15:0], b};
			n = 4;
		end else if (last) begin
			if (grp_cnt == 2'd0) begin
				triple = {b, 16'h0000};
				n = 2;
			end else begin
				triple = {grp_bits[7:0], b, 8'h00};
				n = 3;
			end
		end else begin
			grp_bits = {grp_bits[9:0], b};
			grp_cnt++;
			return;
		end
		for (int k = 0; k < n; k++)
			push_result(url_char(int'(triple[18-6*k +: 6])), last && k == n - 1, 1'b0);
		clear_group();
	endtask

	task automatic decode_char(input logic [7:0] c, input logic last);
		int v;
		int pos;
		logic [17:0] bits;
		if (drop_rest) begin
			if (last) drop_rest = 1'b0;
			return;
		end
		v = sym_value(c);
		pos = grp_cnt;
		if (v == SYM_BAD) begin
			decode_fail(last);
			return;
		end
		if (v == SYM_PAD) begin
			if (pos < 2) begin
				decode_fail(last);
				return;
			end
			pad_seen |= (pos == 2) ? 2'b01 : 2'b10;
			v = 0;
		end else if (pos == 3 && pad_seen[0]) begin
			// only padding may follow a pad in the third slot
			decode_fail(last);
			return;
		end
		if (pos == 3) begin
			emit_bytes({grp_bits, 6'(v)}, pad_seen[0] ? 1 : (pad_seen[1] ? 2 : 3), last);
			return;
		end
		bits = {grp_bits[11:0], 6'(v)};
		if (last) begin
			if (pos == 0) decode_fail(last);
			else if (pos == 1) emit_bytes({bits[11:0], 12'h000}, 1, last);
			else emit_bytes({bits, 6'h00}, pad_seen[0] ? 1 : 2, last);
			return;
		end
		grp_bits = bits;
		grp_cnt  = 2'(pos + 1);
	endtask

	task automatic codec_step(input in_item_t it);
		if (dec_mode == MODE_DECODE) decode_char(it.in_byte, it.in_last);
		else encode_byte(it.in_byte, it.in_last);
	endtask

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) set_mode(cfg_data);
			if (in_valid && !in_stall) codec_step(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					in_data  <= items_to_send.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: changing stall pattern plus one long hold-off
	int           results_seen = 0;
	int           hold_left    = 0;
	bit           hold_done    = 1'b0;
	int           style_left   = 0;
	stall_style_t stall_style  = STALL_NONE;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result beat: out_byte=%h out_last=%b error=%b",
						out_data.out_byte, out_data.out_last, out_data.error);
					err_count++;
				end else begin
					want_beat = pending_results.pop_front();
					if (out_data.out_byte !== want_beat.out_byte) begin
						$error("out_byte: expected %h, actual %h",
							want_beat.out_byte, out_data.out_byte);
						err_count++;
					end
					if (out_data.out_last !== want_beat.out_last) begin
						$error("out_last: expected %b, actual %b",
							want_beat.out_last, out_data.out_last);
						err_count++;
					end
					if (out_data.error !== want_beat.error) begin
						$error("error: expected %b, actual %b",
							want_beat.error, out_data.error);
						err_count++;
					end
				end
			end
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (style_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 80);
			end else begin
				style_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_style)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= ~out_stall;
				endcase
			end
		end
	end

	task automatic queue_item(input logic [7:0] b, input logic last);
		in_item_t r;
		r = '{in_byte: b, in_last: last};
		items_to_send.insert(items_to_send.size(), r);
		items_queued++;
	endtask

	task automatic queue_text(input string s, input logic close_msg);
		for (int i = 0; i < s.len(); i++)
			queue_item(s[i], close_msg && i == s.len() - 1);
	endtask

	task automatic queue_raw_msg();
		int n;
		bit close_msg;
		n = $urandom_range(1, 8);
		close_msg = ($urandom_range(0, 5) != 0);
		for (int i = 0; i < n; i++)
			queue_item(8'($urandom_range(0, 255)), close_msg && i == n - 1);
	endtask

	// mostly well-formed text, with padding now and then and a little noise
	task automatic queue_text_msg();
		int n;
		int pads;
		int v;
		logic [7:0] c;
		n = $urandom_range(1, 10);
		pads = 0;
		if (n % 4 == 2 && $urandom_range(0, 1)) pads = 2;
		else if (n % 4 == 3 && $urandom_range(0, 1)) pads = 1;
		for (int i = 0; i < n + pads; i++) begin
			if (i >= n) begin
				c = "=";
			end else begin
				v = $urandom_range(0, 63);
				c = url_char(v);
				if (v == 62 && $urandom_range(0, 1)) c = "+";
				if (v == 63 && $urandom_range(0, 1)) c = "/";
			end
			if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(0, 255));
			queue_item(c, i == n + pads - 1);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (items_to_send.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int mark;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_mode(MODE_ENCODE);
		queue_item(8'h00, 1'b1);
		queue_item(8'hFF, 1'b0);
		queue_item(8'hFE, 1'b1);
		queue_item(8'hFB, 1'b0);
		queue_item(8'hFF, 1'b0);
		queue_item(8'h00, 1'b1);
		queue_item(8'h01, 1'b0);
		queue_item(8'h02, 1'b0);
		queue_item(8'h03, 1'b0);
		queue_item(8'h80, 1'b1);

		write_mode(MODE_DECODE);
		queue_text("TWFu", 1'b1);
		queue_text("TQ==", 1'b1);
		queue_text("TWE", 1'b1);
		queue_text("-_", 1'b1);
		queue_text("+/A=", 1'b1);
		queue_text("z", 1'b1);
		// pad in the first slot, then the rest of the message is dropped
		queue_text("=", 1'b0);
		queue_text("9", 1'b1);
		queue_text("TW=A", 1'b1);
		queue_text("TQ==TWFu", 1'b1);
		queue_item(8'hFF, 1'b1);

		write_mode(MODE_ENCODE);
		mark = items_queued;
		while (items_queued - mark < 16) queue_raw_msg();
		// sender pauses until everything is out
		wait_idle();
		mark = items_queued;
		while (items_queued - mark < 8) queue_raw_msg();

		write_mode(MODE_DECODE);
		mark = items_queued;
		while (items_queued - mark < 32) queue_text_msg();

		write_mode(MODE_ENCODE);
		mark = items_queued;
		while (items_queued - mark < 8) queue_raw_msg();

		wait_idle();
		if (err_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
